/* hw/rtl/csd_pkg.sv */
package csd_pkg;

   localparam int VALUE_W          = 7;
   localparam int COUNT_W          = 7;
   localparam int MAX_ITEMS_DEF    = 64;
   localparam int VALUE_LEVELS_DEF = 128;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_FLUSH,
      ST_READ,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic walk_init;
      logic read;
      logic drain;
      logic next_level;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic accept_last;
      logic level_zero;
      logic level_empty;
      logic batch_done;
   } status_type;

endpackage

/* hw/rtl/csd_if.sv */
interface csd_req_if;
   logic                        valid;
   logic                        ready;
   logic [csd_pkg::VALUE_W-1:0] value;
   logic                        last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface csd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csd_pkg::VALUE_W-1:0] sorted_value;
   logic                        final_res;

   modport source (output valid, output sorted_value, output final_res, input ready);
   modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

/* hw/rtl/counting_sort_descending_core.sv */
// channel   dir  beat fields               accepted when
// req_ch    in   value[6:0], last          valid && ready
// rsp_ch    out  sorted_value[6:0], final_res  valid && ready
//
// Load: one value per cycle; ready stays high until a beat with last is taken.
// Sort: flush, then a read and a drain state per level from the batch maximum down;
//   drain emits the level's results. The memory has separate read and write ports.
// After reset the histogram is cleared level by level from 0 up; ready stays low.
// Stall on rsp_ch holds the walk; the output register takes a new beat as the
//   previous one drains.
module counting_sort_descending_core #(
   parameter int MAX_ITEMS    = csd_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_LEVELS = csd_pkg::VALUE_LEVELS_DEF
) (
   input logic      clock,
   input logic      reset,
   csd_req_if.sink  req_ch,
   csd_rsp_if.source rsp_ch
);

   csd_pkg::cmd_type    cmd;
   csd_pkg::status_type status;

   assign req_ch.ready = cmd.load;

   csd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   csd_datapath #(
      .MAX_ITEMS    (MAX_ITEMS),
      .VALUE_LEVELS (VALUE_LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_ch.valid),
      .req_value        (req_ch.value),
      .req_last         (req_ch.last),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_sorted_value (rsp_ch.sorted_value),
      .rsp_final_res    (rsp_ch.final_res)
   );

endmodule

/* hw/rtl/csd_ctrl.sv */
module csd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  csd_pkg::status_type status,
   output csd_pkg::cmd_type    cmd
);

   csd_pkg::state_type state_ff;
   csd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csd_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = csd_pkg::ST_LOAD;
         end
         csd_pkg::ST_LOAD: begin
            if (status.accept_last) state_in = csd_pkg::ST_FLUSH;
         end
         csd_pkg::ST_FLUSH: begin
            state_in = csd_pkg::ST_READ;
         end
         csd_pkg::ST_READ: begin
            state_in = csd_pkg::ST_DRAIN;
         end
         csd_pkg::ST_DRAIN: begin
            if (status.batch_done) begin
               state_in = csd_pkg::ST_LOAD;
            end else if (status.level_empty) begin
               state_in = status.level_zero ? csd_pkg::ST_LOAD : csd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = csd_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         csd_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         csd_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
         end
         csd_pkg::ST_FLUSH: begin
            cmd.walk_init = 1'b1;
         end
         csd_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         csd_pkg::ST_DRAIN: begin
            cmd.drain = 1'b1;
            if (status.batch_done) begin
               cmd.finish = 1'b1;
            end else if (status.level_empty) begin
               if (status.level_zero) begin
                  cmd.finish = 1'b1;
               end else begin
                  cmd.next_level = 1'b1;
               end
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* hw/rtl/csd_datapath.sv */
module csd_datapath #(
   parameter int MAX_ITEMS    = csd_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_LEVELS = csd_pkg::VALUE_LEVELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  csd_pkg::cmd_type            cmd,
   output csd_pkg::status_type         status,
   input  logic                        req_valid,
   input  logic [csd_pkg::VALUE_W-1:0] req_value,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [csd_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                        rsp_final_res
);

   localparam int VW = csd_pkg::VALUE_W;
   localparam int NW = csd_pkg::COUNT_W;
   localparam int LW = $clog2(VALUE_LEVELS);
   localparam int CW = (LW > VW) ? LW : VW;
   localparam int IW = $clog2(MAX_ITEMS + 1);

   logic [NW-1:0] hist_mem [VALUE_LEVELS];

   logic [IW-1:0] item_count_ff, item_count_in;
   logic [LW-1:0] max_ff, max_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [NW-1:0] rd_ff;
   logic          take_ff;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          p_valid_ff;
   logic [LW-1:0] p_addr_ff;
   logic          w_valid_ff;
   logic [LW-1:0] w_addr_ff;
   logic [NW-1:0] w_data_ff;
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_final_ff;

   logic [CW-1:0] v_ext;
   logic [LW-1:0] v_lvl;
   logic          accept;
   logic          count_ok;
   logic          add_item;
   logic [NW-1:0] load_base;
   logic [NW-1:0] load_inc;
   logic [NW-1:0] cur_cnt;
   logic          emit_ok;
   logic          emit_fire;
   logic [LW-1:0] rd_addr;
   logic          wr_en;
   logic [LW-1:0] wr_addr;
   logic [NW-1:0] wr_data;

   assign v_ext    = CW'(req_value);
   assign v_lvl    = (v_ext > CW'(VALUE_LEVELS - 1)) ? LW'(VALUE_LEVELS - 1) : LW'(v_ext);
   assign accept   = cmd.load && req_valid;
   assign count_ok = item_count_ff < IW'(MAX_ITEMS);
   assign add_item = accept && count_ok;

   // forward the previous cycle's write on back-to-back hits
   assign load_base = (w_valid_ff && (w_addr_ff == p_addr_ff)) ? w_data_ff : rd_ff;
   assign load_inc  = load_base + NW'(1);

   assign cur_cnt   = take_ff ? rd_ff : cnt_ff;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign emit_fire = cmd.drain && (cur_cnt != '0) && (item_count_ff != '0) && emit_ok;

   assign rd_addr = cmd.load ? v_lvl : lvl_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lvl_ff;
      wr_data = '0;
      if (p_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = p_addr_ff;
         wr_data = load_inc;
      end else if (cmd.clear || (cmd.drain && take_ff)) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_ff <= hist_mem[rd_addr];
   end

   always_comb begin
      item_count_in = item_count_ff;
      if (cmd.finish) begin
         item_count_in = '0;
      end else if (add_item) begin
         item_count_in = item_count_ff + IW'(1);
      end else if (emit_fire) begin
         item_count_in = item_count_ff - IW'(1);
      end
   end

   always_comb begin
      max_in = max_ff;
      if (cmd.finish) begin
         max_in = '0;
      end else if (add_item && (v_lvl > max_ff)) begin
         max_in = v_lvl;
      end
   end

   always_comb begin
      lvl_in = lvl_ff;
      if (cmd.clear) begin
         lvl_in = lvl_ff + LW'(1);
      end else if (cmd.walk_init) begin
         lvl_in = max_ff;
      end else if (cmd.next_level) begin
         lvl_in = lvl_ff - LW'(1);
      end
   end

   assign cnt_in = emit_fire ? (cur_cnt - NW'(1)) : cur_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         max_ff        <= '0;
         lvl_ff        <= '0;
         take_ff       <= 1'b0;
         p_valid_ff    <= 1'b0;
         w_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_count_ff <= item_count_in;
         max_ff        <= max_in;
         lvl_ff        <= lvl_in;
         take_ff       <= cmd.read;
         p_valid_ff    <= add_item;
         w_valid_ff    <= p_valid_ff;
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      p_addr_ff <= v_lvl;
      w_addr_ff <= p_addr_ff;
      w_data_ff <= load_inc;
      if (emit_fire) begin
         rsp_value_ff <= VW'(CW'(lvl_ff));
         rsp_final_ff <= item_count_ff == IW'(1);
      end
   end

   assign status.clear_last  = lvl_ff == LW'(VALUE_LEVELS - 1);
   assign status.accept_last = accept && req_last;
   assign status.level_zero  = lvl_ff == '0;
   assign status.level_empty = cur_cnt == '0;
   assign status.batch_done  = item_count_ff == '0;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_res    = rsp_final_ff;

endmodule

/* sim/counting_sort_descending_core_tb.sv */
`timescale 1ns / 1ps

module counting_sort_descending_core_tb;

   localparam int MAX_ITEMS      = csd_pkg::MAX_ITEMS_DEF;
   localparam int VALUE_LEVELS   = csd_pkg::VALUE_LEVELS_DEF;
   localparam int RANDOM_LOADS   = 200;
   localparam int TAIL_BEATS     = 40;
   localparam int DRAIN_CYCLES   = 2 * VALUE_LEVELS + MAX_ITEMS + 80;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [csd_pkg::VALUE_W-1:0] value;
      logic                        last;
   } load_beat_type;

   typedef struct packed {
      logic [csd_pkg::VALUE_W-1:0] sorted_value;
      logic                        final_res;
   } sorted_beat_type;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_FLAT
   } spread_mode_type;

   logic clock = 1'b0;
   logic reset;

   csd_req_if req_bus ();
   csd_rsp_if rsp_bus ();

   counting_sort_descending_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   load_beat_type   pending_loads[$];
   sorted_beat_type sorted_expect[$];

   logic [csd_pkg::COUNT_W-1:0] tally [VALUE_LEVELS];
   int unsigned                 tally_items;
   int unsigned                 peak_value;

   bit idle_on;
   int req_gap;
   int rsp_gap;
   int quiet_cycles;
   int mismatches = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic add_load(input int v, input bit is_last);
      load_beat_type b;
      b.value = v[csd_pkg::VALUE_W-1:0];
      b.last  = is_last;
      pending_loads.push_back(b);
   endtask

   task automatic clear_tally();
      foreach (tally[i]) tally[i] = '0;
      tally_items = 0;
      peak_value  = 0;
   endtask

   // count one value; on the closing beat queue the batch largest first
   task automatic tally_and_sort(input logic [csd_pkg::VALUE_W-1:0] value,
                                 input logic is_last);
      int unsigned     lvl;
      int unsigned     emitted;
      sorted_beat_type beat;
      lvl = (value > VALUE_LEVELS - 1) ? VALUE_LEVELS - 1 : value;
      if (tally_items < MAX_ITEMS) begin
         tally[lvl] = tally[lvl] + 1'b1;
         tally_items++;
         if (lvl > peak_value) peak_value = lvl;
      end
      if (!is_last) return;
      emitted = 0;
      for (int l = int'(peak_value); l >= 0; l--) begin
         for (int k = 0; k < int'(tally[l]) && emitted < tally_items; k++) begin
            beat.sorted_value = l[csd_pkg::VALUE_W-1:0];
            beat.final_res    = (emitted == tally_items - 1);
            sorted_expect.push_back(beat);
            emitted++;
         end
      end
      clear_tally();
   endtask

   always @(posedge clock) begin
      load_beat_type next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         req_bus.last  <= 1'b0;
         idle_on       <= 1'b1;
         req_gap = 0;
      end else begin
         idle_on <= pending_loads.size() > TAIL_BEATS;
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap == 0 && idle_on && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 5);
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_loads.size() > 0) begin
               next_beat = pending_loads.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.value <= next_beat.value;
               req_bus.last  <= next_beat.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sorted_beat_type want;
      bit              moved;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap      = 0;
         quiet_cycles = 0;
         clear_tally();
      end else begin
         moved = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (sorted_expect.size() == 0) begin
               report_mismatch("unexpected sorted beat", rsp_bus.sorted_value, -1);
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_bus.sorted_value !== want.sorted_value)
                  report_mismatch("sorted_value", rsp_bus.sorted_value, want.sorted_value);
               if (rsp_bus.final_res !== want.final_res)
                  report_mismatch("final_res", rsp_bus.final_res, want.final_res);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            tally_and_sort(req_bus.value, req_bus.last);
         end

         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end

         if (rsp_gap == 0 && idle_on && $urandom_range(0, 3) == 0)
            rsp_gap = $urandom_range(1, 5);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int              queued;
      int              len;
      int              base;
      int              v;
      spread_mode_type mode;

      reset = 1'b1;

      // single-value batches at both extremes
      add_load(VALUE_LEVELS - 1, 1'b1);
      add_load(0, 1'b1);
      // duplicates and extremes mixed
      add_load(5, 1'b0);
      add_load(127, 1'b0);
      add_load(0, 1'b0);
      add_load(5, 1'b0);
      add_load(64, 1'b0);
      add_load(127, 1'b0);
      add_load(1, 1'b1);
      // one value repeated
      add_load(3, 1'b0);
      add_load(3, 1'b0);
      add_load(3, 1'b1);
      // alternating bit patterns
      add_load(85, 1'b0);
      add_load(42, 1'b1);

      queued = 0;
      while (queued < RANDOM_LOADS) begin
         if (queued == 0)
            len = MAX_ITEMS + 3;
         else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6);
         else
            len = $urandom_range(1, 16);
         mode = spread_mode_type'($urandom_range(0, 2));
         base = $urandom_range(0, VALUE_LEVELS - 1);
         for (int i = 0; i < len; i++) begin
            case (mode)
               SPREAD_FULL:   v = $urandom_range(0, VALUE_LEVELS - 1);
               SPREAD_NARROW: v = base ^ $urandom_range(0, 3);
               default:       v = base;
            endcase
            add_load(v, i == len - 1);
         end
         queued += len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_loads.size() > 0 || req_bus.valid) @(negedge clock);
      while (sorted_expect.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/csd_pkg.sv
hw/rtl/csd_if.sv
hw/rtl/csd_ctrl.sv
hw/rtl/csd_datapath.sv
hw/rtl/counting_sort_descending_core.sv
sim/counting_sort_descending_core_tb.sv
